FILE: sv/gregorian_date_arithmetic_defines.svh
// ----------------------------------------------------------------------------
// Gregorian date calculator assertion macros
// Shared checks written against the clk and arst_n of the using module.
// ----------------------------------------------------------------------------
`ifndef GREGORIAN_DATE_ARITHMETIC_DEFINES_SVH
`define GREGORIAN_DATE_ARITHMETIC_DEFINES_SVH

// consequent holds in the same cycle as the antecedent
`define GDA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent holds in the cycle after the antecedent
`define GDA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/gda_pkg.sv
// ----------------------------------------------------------------------------
// Gregorian date calculator package
// Widths, microcode word layout, program addresses and calendar helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gda_pkg;

	localparam int DEF_MAX_YEAR = 9999;
	// day numbers up to year 65535 plus the widest offset, signed
	localparam int NUM_W = 26;
	// year residue and year count up to 65536
	localparam int YR_W  = 17;
	localparam int PC_W  = 5;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_BAD_DATE = 2'd1,
		ST_RANGE    = 2'd2
	} status_t;

	typedef enum logic [4:0] {
		OP_NOP,
		OP_LOAD_A,
		OP_STEP400,
		OP_STEP100,
		OP_STEP4,
		OP_STEP1,
		OP_ADD_MON,
		OP_ADD_DAY,
		OP_LOAD_B,
		OP_ADD_OFF,
		OP_INV_INIT,
		OP_INV400,
		OP_INV100,
		OP_INV4,
		OP_INV1,
		OP_INV_YEAR,
		OP_INV_MON,
		OP_FIN_DATE,
		OP_FIN_DIFF,
		OP_FIN_BAD,
		OP_FIN_OOR,
		OP_PUBLISH
	} op_t;

	typedef enum logic [4:0] {
		C_ALWAYS,
		C_RANGE_BAD,
		C_RES_GE400,
		C_RES_GE100,
		C_RES_GE4,
		C_RES_GE1,
		C_DAY_BAD,
		C_MON_LT,
		C_SEL_B,
		C_KIND1,
		C_T_OUT,
		C_NUM_GE400Y,
		C_NUM_GE100Y,
		C_NUM_GE4Y,
		C_NUM_GE1Y,
		C_MON_FIT,
		C_OUT_BUSY
	} cond_t;

	// program addresses
	localparam logic [PC_W-1:0] PC_IDLE      = 5'd0;
	localparam logic [PC_W-1:0] PC_LOAD_A    = 5'd1;
	localparam logic [PC_W-1:0] PC_CHK_RANGE = 5'd2;
	localparam logic [PC_W-1:0] PC_FY400     = 5'd3;
	localparam logic [PC_W-1:0] PC_FY100     = 5'd4;
	localparam logic [PC_W-1:0] PC_FY4       = 5'd5;
	localparam logic [PC_W-1:0] PC_FY1       = 5'd6;
	localparam logic [PC_W-1:0] PC_CHK_DAY   = 5'd7;
	localparam logic [PC_W-1:0] PC_FMON      = 5'd8;
	localparam logic [PC_W-1:0] PC_FDAY      = 5'd9;
	localparam logic [PC_W-1:0] PC_SEL       = 5'd10;
	localparam logic [PC_W-1:0] PC_KIND      = 5'd11;
	localparam logic [PC_W-1:0] PC_OFF       = 5'd12;
	localparam logic [PC_W-1:0] PC_CHK_OUT   = 5'd13;
	localparam logic [PC_W-1:0] PC_IINIT     = 5'd14;
	localparam logic [PC_W-1:0] PC_I400      = 5'd15;
	localparam logic [PC_W-1:0] PC_I100      = 5'd16;
	localparam logic [PC_W-1:0] PC_I4        = 5'd17;
	localparam logic [PC_W-1:0] PC_I1        = 5'd18;
	localparam logic [PC_W-1:0] PC_IYEAR     = 5'd19;
	localparam logic [PC_W-1:0] PC_IMON      = 5'd20;
	localparam logic [PC_W-1:0] PC_IDATE     = 5'd21;
	localparam logic [PC_W-1:0] PC_DIFF      = 5'd22;
	localparam logic [PC_W-1:0] PC_BAD       = 5'd23;
	localparam logic [PC_W-1:0] PC_OOR       = 5'd24;
	localparam logic [PC_W-1:0] PC_WAIT      = 5'd25;
	localparam logic [PC_W-1:0] PC_PUBLISH   = 5'd26;

	// a taken condition runs the op and jumps to tgt; otherwise fall through
	typedef struct packed {
		op_t             op;
		cond_t           cond;
		logic [PC_W-1:0] tgt;
	} ctrl_word_t;

	typedef struct packed {
		logic        kind;
		logic [13:0] year_a;
		logic [3:0]  month_a;
		logic [4:0]  day_a;
		logic signed [20:0] offset_days;
		logic [13:0] year_b;
		logic [3:0]  month_b;
		logic [4:0]  day_b;
	} in_item_t;

	typedef struct packed {
		logic [13:0]        year;
		logic [3:0]         month;
		logic [4:0]         day;
		logic signed [22:0] diff;
		logic               a_before_b;
		status_t            status;
	} result_t;

	localparam logic [4:0] MONTH_LEN [13] = '{
		5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
		5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
	};

	function automatic logic [4:0] month_days(input logic [3:0] m, input logic lp);
		logic [4:0] len;
		len = 5'd0;
		if (m == 4'd2 && lp) begin
			len = 5'd29;
		end else if (m <= 4'd12) begin
			len = MONTH_LEN[m];
		end
		return len;
	endfunction

	// days from the first day of year 1 to the first day of year y
	function automatic int days_before_year(input int y);
		int p;
		p = y - 1;
		return 365 * p + p / 4 - p / 100 + p / 400;
	endfunction

endpackage

FILE: sv/gda_ucode_rom.sv
// ----------------------------------------------------------------------------
// Gregorian date calculator control store
// One control word per program step: datapath op, jump condition, target.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gda_ucode_rom import gda_pkg::*; (
	input  logic [PC_W-1:0] pc,
	output ctrl_word_t      word
);

	always_comb begin
		case (pc)
			// date to day number: 400, 100, 4 and 1 year blocks, then months
			PC_LOAD_A:    word = '{op: OP_LOAD_A,   cond: C_ALWAYS,     tgt: PC_CHK_RANGE};
			PC_CHK_RANGE: word = '{op: OP_NOP,      cond: C_RANGE_BAD,  tgt: PC_BAD};
			PC_FY400:     word = '{op: OP_STEP400,  cond: C_RES_GE400,  tgt: PC_FY400};
			PC_FY100:     word = '{op: OP_STEP100,  cond: C_RES_GE100,  tgt: PC_FY100};
			PC_FY4:       word = '{op: OP_STEP4,    cond: C_RES_GE4,    tgt: PC_FY4};
			PC_FY1:       word = '{op: OP_STEP1,    cond: C_RES_GE1,    tgt: PC_FY1};
			PC_CHK_DAY:   word = '{op: OP_NOP,      cond: C_DAY_BAD,    tgt: PC_BAD};
			PC_FMON:      word = '{op: OP_ADD_MON,  cond: C_MON_LT,     tgt: PC_FMON};
			PC_FDAY:      word = '{op: OP_ADD_DAY,  cond: C_ALWAYS,     tgt: PC_SEL};
			PC_SEL:       word = '{op: OP_NOP,      cond: C_SEL_B,      tgt: PC_DIFF};
			// second date for a difference: save A and run the same code on B
			PC_KIND:      word = '{op: OP_LOAD_B,   cond: C_KIND1,      tgt: PC_CHK_RANGE};
			PC_OFF:       word = '{op: OP_ADD_OFF,  cond: C_ALWAYS,     tgt: PC_CHK_OUT};
			PC_CHK_OUT:   word = '{op: OP_NOP,      cond: C_T_OUT,      tgt: PC_OOR};
			// day number back to a date
			PC_IINIT:     word = '{op: OP_INV_INIT, cond: C_ALWAYS,     tgt: PC_I400};
			PC_I400:      word = '{op: OP_INV400,   cond: C_NUM_GE400Y, tgt: PC_I400};
			PC_I100:      word = '{op: OP_INV100,   cond: C_NUM_GE100Y, tgt: PC_I100};
			PC_I4:        word = '{op: OP_INV4,     cond: C_NUM_GE4Y,   tgt: PC_I4};
			PC_I1:        word = '{op: OP_INV1,     cond: C_NUM_GE1Y,   tgt: PC_I1};
			PC_IYEAR:     word = '{op: OP_INV_YEAR, cond: C_ALWAYS,     tgt: PC_IMON};
			PC_IMON:      word = '{op: OP_INV_MON,  cond: C_MON_FIT,    tgt: PC_IMON};
			PC_IDATE:     word = '{op: OP_FIN_DATE, cond: C_ALWAYS,     tgt: PC_WAIT};
			PC_DIFF:      word = '{op: OP_FIN_DIFF, cond: C_ALWAYS,     tgt: PC_WAIT};
			PC_BAD:       word = '{op: OP_FIN_BAD,  cond: C_ALWAYS,     tgt: PC_WAIT};
			PC_OOR:       word = '{op: OP_FIN_OOR,  cond: C_ALWAYS,     tgt: PC_WAIT};
			// hold until the output register is free, then hand the item over
			PC_WAIT:      word = '{op: OP_NOP,      cond: C_OUT_BUSY,   tgt: PC_WAIT};
			PC_PUBLISH:   word = '{op: OP_PUBLISH,  cond: C_ALWAYS,     tgt: PC_IDLE};
			default:      word = '{op: OP_NOP,      cond: C_ALWAYS,     tgt: PC_IDLE};
		endcase
	end

endmodule

FILE: sv/gda_datapath.sv
// ----------------------------------------------------------------------------
// Gregorian date calculator datapath
// Year and day-number registers, block counters, condition flags, result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gda_datapath import gda_pkg::*; #(
	parameter int MAX_YEAR = DEF_MAX_YEAR
) (
	input  logic       clk,
	input  logic       ld,
	input  in_item_t   item,
	input  logic       en,
	input  ctrl_word_t ctrl,
	input  logic       out_busy,
	output logic       cond_hit,
	output result_t    result
);

	localparam logic [YR_W-1:0] MAX_Y = YR_W'(MAX_YEAR);
	localparam logic signed [NUM_W-1:0] DAYS_END = NUM_W'(days_before_year(MAX_YEAR + 1));
	localparam logic signed [NUM_W-1:0] D400 = NUM_W'(146097);
	localparam logic signed [NUM_W-1:0] D100 = NUM_W'(36524);
	localparam logic signed [NUM_W-1:0] D4   = NUM_W'(1461);
	localparam logic signed [NUM_W-1:0] D1   = NUM_W'(365);
	localparam logic signed [NUM_W:0] DIFF_MAX = (NUM_W + 1)'(4194303);
	localparam logic signed [NUM_W:0] DIFF_MIN = (NUM_W + 1)'(-4194304);

	in_item_t                 item_q;
	logic                     sel_q;
	logic [YR_W-1:0]          res_q;
	logic signed [NUM_W-1:0]  num_q;
	logic signed [NUM_W-1:0]  na_q;
	logic [1:0]               b_q;
	logic [4:0]               c_q;
	logic [1:0]               d_q;
	logic [3:0]               mon_q;
	result_t                  res_out_q;

	logic [13:0]             cur_y;
	logic [3:0]              cur_m;
	logic [4:0]              cur_d;
	logic                    leap;
	logic [4:0]              dim_mon;
	logic [4:0]              dim_cur;
	logic signed [NUM_W-1:0] dim_mon_s;
	logic signed [NUM_W-1:0] day_s;
	logic                    range_bad;
	logic signed [NUM_W:0]   dif;
	logic                    exec;

	assign cur_y = sel_q ? item_q.year_b  : item_q.year_a;
	assign cur_m = sel_q ? item_q.month_b : item_q.month_a;
	assign cur_d = sel_q ? item_q.day_b   : item_q.day_a;

	// last year of a 4-year block, unless it closes a century that is not the 400th
	assign leap = (d_q == 2'd3) && ((c_q != 5'd24) || (b_q == 2'd3));

	assign dim_mon   = month_days(mon_q, leap);
	assign dim_cur   = month_days(cur_m, leap);
	assign dim_mon_s = $signed({{(NUM_W - 5){1'b0}}, dim_mon});
	assign day_s     = $signed({{(NUM_W - 5){1'b0}}, cur_d});

	assign range_bad = (cur_y == 14'd0) || ({{(YR_W - 14){1'b0}}, cur_y} > MAX_Y) ||
		(cur_m == 4'd0) || (cur_m > 4'd12) || (cur_d == 5'd0);

	assign dif = {na_q[NUM_W-1], na_q} - {num_q[NUM_W-1], num_q};

	always_comb begin
		case (ctrl.cond)
			C_ALWAYS:     cond_hit = 1'b1;
			C_RANGE_BAD:  cond_hit = range_bad;
			C_RES_GE400:  cond_hit = res_q >= YR_W'(400);
			C_RES_GE100:  cond_hit = res_q >= YR_W'(100);
			C_RES_GE4:    cond_hit = res_q >= YR_W'(4);
			C_RES_GE1:    cond_hit = res_q != '0;
			C_DAY_BAD:    cond_hit = cur_d > dim_cur;
			C_MON_LT:     cond_hit = mon_q < cur_m;
			C_SEL_B:      cond_hit = sel_q;
			C_KIND1:      cond_hit = item_q.kind;
			C_T_OUT:      cond_hit = (num_q < 0) || (num_q >= DAYS_END);
			C_NUM_GE400Y: cond_hit = num_q >= D400;
			// the fourth century of a cycle and the fourth year of a block are longer
			C_NUM_GE100Y: cond_hit = (b_q != 2'd3) && (num_q >= D100);
			C_NUM_GE4Y:   cond_hit = num_q >= D4;
			C_NUM_GE1Y:   cond_hit = (d_q != 2'd3) && (num_q >= D1);
			C_MON_FIT:    cond_hit = (mon_q < 4'd12) && (num_q >= dim_mon_s);
			C_OUT_BUSY:   cond_hit = out_busy;
			default:      cond_hit = 1'b0;
		endcase
	end

	assign exec = en && cond_hit;

	always_ff @(posedge clk) begin
		if (ld) begin
			item_q <= item;
		end
		if (exec) begin
			case (ctrl.op)
				OP_LOAD_A: begin
					sel_q  <= 1'b0;
					res_q  <= {{(YR_W - 14){1'b0}}, item_q.year_a} - YR_W'(1);
					num_q  <= '0;
					b_q    <= '0;
					c_q    <= '0;
					d_q    <= '0;
					mon_q  <= 4'd1;
					res_out_q.year       <= item_q.year_a;
					res_out_q.month      <= item_q.month_a;
					res_out_q.day        <= item_q.day_a;
					res_out_q.diff       <= '0;
					res_out_q.a_before_b <= 1'b0;
					res_out_q.status     <= ST_OK;
				end
				OP_STEP400: begin
					res_q <= res_q - YR_W'(400);
					num_q <= num_q + D400;
				end
				OP_STEP100: begin
					res_q <= res_q - YR_W'(100);
					num_q <= num_q + D100;
					b_q   <= b_q + 2'd1;
				end
				OP_STEP4: begin
					res_q <= res_q - YR_W'(4);
					num_q <= num_q + D4;
					c_q   <= c_q + 5'd1;
				end
				OP_STEP1: begin
					res_q <= res_q - YR_W'(1);
					num_q <= num_q + D1;
					d_q   <= d_q + 2'd1;
				end
				OP_ADD_MON: begin
					num_q <= num_q + dim_mon_s;
					mon_q <= mon_q + 4'd1;
				end
				OP_ADD_DAY: begin
					num_q <= num_q + day_s - NUM_W'(1);
				end
				OP_LOAD_B: begin
					na_q  <= num_q;
					sel_q <= 1'b1;
					res_q <= {{(YR_W - 14){1'b0}}, item_q.year_b} - YR_W'(1);
					num_q <= '0;
					b_q   <= '0;
					c_q   <= '0;
					d_q   <= '0;
					mon_q <= 4'd1;
				end
				OP_ADD_OFF: begin
					num_q <= num_q + NUM_W'(item_q.offset_days);
				end
				OP_INV_INIT: begin
					res_q <= '0;
					b_q   <= '0;
					c_q   <= '0;
					d_q   <= '0;
					mon_q <= 4'd1;
				end
				OP_INV400: begin
					res_q <= res_q + YR_W'(400);
					num_q <= num_q - D400;
				end
				OP_INV100: begin
					res_q <= res_q + YR_W'(100);
					num_q <= num_q - D100;
					b_q   <= b_q + 2'd1;
				end
				OP_INV4: begin
					res_q <= res_q + YR_W'(4);
					num_q <= num_q - D4;
					c_q   <= c_q + 5'd1;
				end
				OP_INV1: begin
					res_q <= res_q + YR_W'(1);
					num_q <= num_q - D1;
					d_q   <= d_q + 2'd1;
				end
				OP_INV_YEAR: begin
					res_q <= res_q + YR_W'(1);
				end
				OP_INV_MON: begin
					num_q <= num_q - dim_mon_s;
					mon_q <= mon_q + 4'd1;
				end
				OP_FIN_DATE: begin
					res_out_q.year  <= res_q[13:0];
					res_out_q.month <= mon_q;
					res_out_q.day   <= num_q[4:0] + 5'd1;
				end
				OP_FIN_DIFF: begin
					// clamp to the signed 23-bit field
					if (dif > DIFF_MAX) begin
						res_out_q.diff <= DIFF_MAX[22:0];
					end else if (dif < DIFF_MIN) begin
						res_out_q.diff <= DIFF_MIN[22:0];
					end else begin
						res_out_q.diff <= dif[22:0];
					end
					res_out_q.a_before_b <= na_q < num_q;
				end
				OP_FIN_BAD: begin
					res_out_q.status <= ST_BAD_DATE;
				end
				OP_FIN_OOR: begin
					res_out_q.status <= ST_RANGE;
				end
				default: begin
				end
			endcase
		end
	end

	assign result = res_out_q;

endmodule

FILE: sv/gregorian_date_arithmetic.sv
// ----------------------------------------------------------------------------
// Gregorian date calculator
// The microcode loops step through 400-year blocks, centuries, 4-year blocks, years
// and months, once per date and once more to turn a shifted day number back; a
// finished result waits while a previous one still blocks the output register.
// Throughput: one item at a time; the next is taken the cycle after the result
// enters the output register. Reset clears sequencer and output valid only.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "gregorian_date_arithmetic_defines.svh"

module gregorian_date_arithmetic import gda_pkg::*; #(
	parameter int MAX_YEAR = DEF_MAX_YEAR
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// year_a[13:0] month_a[17:14] day_a[22:18] offset_days[43:23]
	// year_b[57:44] month_b[61:58] day_b[66:62], zero pad[71:67]
	input  logic [71:0] s_tdata,
	// kind[0]
	input  logic        s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// result_year[13:0] result_month[17:14] result_day[22:18]
	// day_difference[45:23] a_before_b[46], zero pad[47]
	output logic [47:0] m_tdata,
	// status[1:0]
	output logic [1:0]  m_tuser
);

	logic            busy_q;
	logic [PC_W-1:0] pc_q;
	logic            m_tvalid_q;
	result_t         out_q;

	ctrl_word_t ctrl;
	in_item_t   item;
	result_t    dp_result;
	logic       cond_hit;
	logic       accept;
	logic       publish;
	logic       out_busy;

	assign s_tready = !busy_q;
	assign accept   = s_tvalid && !busy_q;
	assign out_busy = m_tvalid_q && !m_tready;
	assign publish  = busy_q && cond_hit && (ctrl.op == OP_PUBLISH);

	assign item.kind        = s_tuser;
	assign item.year_a      = s_tdata[13:0];
	assign item.month_a     = s_tdata[17:14];
	assign item.day_a       = s_tdata[22:18];
	assign item.offset_days = s_tdata[43:23];
	assign item.year_b      = s_tdata[57:44];
	assign item.month_b     = s_tdata[61:58];
	assign item.day_b       = s_tdata[66:62];

	gda_ucode_rom u_rom (
		.pc   (pc_q),
		.word (ctrl)
	);

	gda_datapath #(
		.MAX_YEAR (MAX_YEAR)
	) u_dp (
		.clk      (clk),
		.ld       (accept),
		.item     (item),
		.en       (busy_q),
		.ctrl     (ctrl),
		.out_busy (out_busy),
		.cond_hit (cond_hit),
		.result   (dp_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pc_q   <= PC_IDLE;
		end else if (accept) begin
			busy_q <= 1'b1;
			pc_q   <= PC_LOAD_A;
		end else if (busy_q) begin
			if (cond_hit) begin
				pc_q <= ctrl.tgt;
			end else begin
				pc_q <= pc_q + PC_W'(1);
			end
			if (publish) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (publish) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (publish) begin
			out_q <= dp_result;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {1'b0, out_q.a_before_b, out_q.diff, out_q.day, out_q.month, out_q.year};
	assign m_tuser  = out_q.status;

	`GDA_ASSERT_NOW(a_idle_at_rest, !busy_q, pc_q == PC_IDLE, "sequencer left idle without an item")
	`GDA_ASSERT_NEXT(a_publish_frees, publish, m_tvalid && s_tready, "result handover did not free the block")
	`GDA_ASSERT_NOW(a_ok_month, m_tvalid_q && (out_q.status == ST_OK),
		(out_q.month != 4'd0) && (out_q.month <= 4'd12) && (out_q.day != 5'd0),
		"result date malformed with ok status")
	`GDA_ASSERT_NOW(a_err_no_diff, m_tvalid_q && (out_q.status != ST_OK),
		(out_q.diff == '0) && !out_q.a_before_b, "difference reported on an error item")

endmodule

FILE: test/tb_gregorian_date_arithmetic.sv
// ----------------------------------------------------------------------------
// Gregorian date calculator testbench
// Sends date shifts and date differences over the input stream, works out
// every answer with a calendar model of its own and checks each output item
// field by field. The first items are hand-picked calendar corners; the rest
// are random, mostly valid dates, with random idling on both streams.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_gregorian_date_arithmetic;
	import gda_pkg::*;

	localparam int MAX_YEAR     = DEF_MAX_YEAR;
	localparam int RANDOM_ITEMS = 1150;
	localparam int STALL_LIMIT  = 4000;
	localparam int SETTLE_TIME  = 250;
	localparam int CALM_TAIL    = 100;
	localparam int OFF_MAX      = 1048575;
	localparam int OFF_MIN      = -1048576;
	localparam int DIFF_MAX     = 4194303;
	localparam int DIFF_MIN     = -4194304;
	localparam bit KIND_SHIFT   = 1'b0;
	localparam bit KIND_DIFF    = 1'b1;
	localparam int BASE_MONTH_LEN [13] = '{0, 31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

	typedef struct {
		in_item_t item;
		bit       hold;
	} request_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [71:0] s_tdata  = '0;
	logic        s_tuser  = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;
	logic [1:0]  m_tuser;

	request_t    date_requests[$];
	result_t     predicted_results[$];
	int unsigned sent_cnt     = 0;
	int unsigned taken_cnt    = 0;
	int unsigned checked_cnt  = 0;
	int unsigned err_cnt      = 0;
	int unsigned stall_cycles = 0;
	int unsigned shift_cnt    = 0;
	int unsigned diff_cnt     = 0;
	int unsigned bad_cnt      = 0;
	int unsigned range_cnt    = 0;
	int          src_gap      = 0;
	int          sink_gap     = 0;

	gregorian_date_arithmetic #(
		.MAX_YEAR(MAX_YEAR)
	) u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// calendar model
	// ------------------------------------------------------------------
	function automatic bit leap_year(input longint y);
		return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
	endfunction

	function automatic longint month_length(input longint y, input longint m);
		if (m < 1 || m > 12) begin
			return 0;
		end
		if (m == 2 && leap_year(y)) begin
			return 29;
		end
		return BASE_MONTH_LEN[m];
	endfunction

	// days from 0001-01-01 to the first of January of year y
	function automatic longint year_start(input longint y);
		longint p;
		p = y - 1;
		return 365 * p + p / 4 - p / 100 + p / 400;
	endfunction

	function automatic bit date_ok(input longint y, input longint m, input longint d);
		if (y < 1 || y > MAX_YEAR || m < 1 || m > 12) begin
			return 1'b0;
		end
		return d >= 1 && d <= month_length(y, m);
	endfunction

	function automatic longint day_index(input longint y, input longint m, input longint d);
		longint n;
		longint k;
		n = year_start(y);
		for (k = 1; k < m; k++) begin
			n += month_length(y, k);
		end
		return n + d - 1;
	endfunction

	function automatic void index_to_date(input longint n, output longint y,
			output longint m, output longint d);
		longint yy;
		longint mm;
		longint rest;
		yy = (n * 400) / 146097 + 1;
		if (yy < 1) begin
			yy = 1;
		end
		while (year_start(yy + 1) <= n) begin
			yy++;
		end
		while (yy > 1 && year_start(yy) > n) begin
			yy--;
		end
		rest = n - year_start(yy);
		mm = 1;
		while (mm < 12 && rest >= month_length(yy, mm)) begin
			rest -= month_length(yy, mm);
			mm++;
		end
		y = yy;
		m = mm;
		d = rest + 1;
	endfunction

	function automatic result_t calc_date_result(input in_item_t it);
		result_t r;
		longint  ya, ma, da, yb, mb, db, off, t, na, nb, ry, rm, rd, dd;
		ya = it.year_a;
		ma = it.month_a;
		da = it.day_a;
		yb = it.year_b;
		mb = it.month_b;
		db = it.day_b;
		off = it.offset_days;
		r.year       = it.year_a;
		r.month      = it.month_a;
		r.day        = it.day_a;
		r.diff       = '0;
		r.a_before_b = 1'b0;
		r.status     = ST_OK;
		if (it.kind == KIND_SHIFT) begin
			if (!date_ok(ya, ma, da)) begin
				r.status = ST_BAD_DATE;
			end else begin
				t = day_index(ya, ma, da) + off;
				if (t < 0 || t >= year_start(longint'(MAX_YEAR) + 1)) begin
					r.status = ST_RANGE;
				end else begin
					index_to_date(t, ry, rm, rd);
					r.year  = ry[13:0];
					r.month = rm[3:0];
					r.day   = rd[4:0];
				end
			end
		end else begin
			if (!date_ok(ya, ma, da) || !date_ok(yb, mb, db)) begin
				r.status = ST_BAD_DATE;
			end else begin
				na = day_index(ya, ma, da);
				nb = day_index(yb, mb, db);
				dd = na - nb;
				if (dd > DIFF_MAX) begin
					dd = DIFF_MAX;
				end
				if (dd < DIFF_MIN) begin
					dd = DIFF_MIN;
				end
				r.diff       = dd[22:0];
				r.a_before_b = na < nb;
			end
		end
		return r;
	endfunction

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------
	function automatic void add_request(input bit kind, input int ya, input int ma,
			input int da, input int off, input int yb, input int mb, input int db,
			input bit hold);
		request_t rq;
		rq.item.kind        = kind;
		rq.item.year_a      = ya[13:0];
		rq.item.month_a     = ma[3:0];
		rq.item.day_a       = da[4:0];
		rq.item.offset_days = off[20:0];
		rq.item.year_b      = yb[13:0];
		rq.item.month_b     = mb[3:0];
		rq.item.day_b       = db[4:0];
		rq.hold             = hold;
		date_requests.push_back(rq);
	endfunction

	// valid date, weighted towards the ends of the year range, centuries and the first and last days of a month
	function automatic void random_date(output int y, output int m, output int d);
		int len;
		case ($urandom_range(0, 5))
			0: y = $urandom_range(1, 4);
			1: y = $urandom_range(MAX_YEAR - 3, MAX_YEAR);
			2: y = int'($urandom_range(1, 99)) * 100 + int'($urandom_range(0, 2)) - 1;
			default: y = $urandom_range(1, MAX_YEAR);
		endcase
		m = $urandom_range(1, 12);
		len = int'(month_length(y, m));
		case ($urandom_range(0, 3))
			0: d = len;
			1: d = 1;
			default: d = $urandom_range(1, len);
		endcase
	endfunction

	task automatic flag_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		err_cnt++;
	endtask

	// ------------------------------------------------------------------
	// drive both streams at the falling edge
	// ------------------------------------------------------------------
	always @(negedge clk) begin : drive_proc
		request_t rq;
		bit       calm;
		if (arst_n) begin
			calm = date_requests.size() < CALM_TAIL || (sent_cnt / 100) % 3 == 2;
			if (!s_tvalid || taken_cnt == sent_cnt) begin
				if (src_gap > 0) begin
					s_tvalid <= 1'b0;
					src_gap--;
				end else if (date_requests.size() > 0
						&& (!date_requests[0].hold || predicted_results.size() == 0)) begin
					rq = date_requests.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= {5'd0, rq.item.day_b, rq.item.month_b, rq.item.year_b,
						rq.item.offset_days, rq.item.day_a, rq.item.month_a, rq.item.year_a};
					s_tuser  <= rq.item.kind;
					sent_cnt++;
					if (!calm && $urandom_range(0, 3) == 0) begin
						src_gap = $urandom_range(1, 13);
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
			if (sink_gap > 0) begin
				m_tready <= 1'b0;
				sink_gap--;
			end else begin
				m_tready <= 1'b1;
				if (!calm && $urandom_range(0, 5) == 0) begin
					sink_gap = $urandom_range(1, 13);
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// sample both streams at the rising edge
	// ------------------------------------------------------------------
	always @(posedge clk) begin : check_proc
		in_item_t it;
		result_t  want;
		result_t  got;
		if (arst_n) begin
			// check outputs before queueing this edge's item, so an early result cannot hide
			if (m_tvalid && m_tready) begin
				got.year       = m_tdata[13:0];
				got.month      = m_tdata[17:14];
				got.day        = m_tdata[22:18];
				got.diff       = m_tdata[45:23];
				got.a_before_b = m_tdata[46];
				got.status     = status_t'(m_tuser);
				if (predicted_results.size() == 0) begin
					flag_mismatch("result item with no request outstanding");
				end else begin
					want = predicted_results.pop_front();
					if (got.year !== want.year)
						flag_mismatch($sformatf("result %0d year %0d, want %0d",
							checked_cnt, got.year, want.year));
					if (got.month !== want.month)
						flag_mismatch($sformatf("result %0d month %0d, want %0d",
							checked_cnt, got.month, want.month));
					if (got.day !== want.day)
						flag_mismatch($sformatf("result %0d day %0d, want %0d",
							checked_cnt, got.day, want.day));
					if (got.diff !== want.diff)
						flag_mismatch($sformatf("result %0d difference %0d, want %0d",
							checked_cnt, got.diff, want.diff));
					if (got.a_before_b !== want.a_before_b)
						flag_mismatch($sformatf("result %0d a_before_b %0b, want %0b",
							checked_cnt, got.a_before_b, want.a_before_b));
					if (got.status !== want.status)
						flag_mismatch($sformatf("result %0d status %0d, want %0d",
							checked_cnt, got.status, want.status));
				end
				checked_cnt++;
			end
			if (s_tvalid && s_tready) begin
				it.kind        = s_tuser;
				it.year_a      = s_tdata[13:0];
				it.month_a     = s_tdata[17:14];
				it.day_a       = s_tdata[22:18];
				it.offset_days = s_tdata[43:23];
				it.year_b      = s_tdata[57:44];
				it.month_b     = s_tdata[61:58];
				it.day_b       = s_tdata[66:62];
				want = calc_date_result(it);
				predicted_results.push_back(want);
				taken_cnt++;
				if (it.kind == KIND_SHIFT) shift_cnt++;
				else diff_cnt++;
				if (want.status == ST_BAD_DATE) bad_cnt++;
				if (want.status == ST_RANGE) range_cnt++;
			end
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				stall_cycles = 0;
			end else begin
				stall_cycles++;
			end
		end
	end

	initial begin : watchdog_proc
		wait (arst_n === 1'b1);
		while (stall_cycles < STALL_LIMIT) begin
			@(negedge clk);
		end
		$display("[%0t] no item moved for %0d cycles", $realtime, STALL_LIMIT);
		$display("Some tests failed");
		$finish;
	end

	initial begin : main_proc
		int     i;
		bit     kind;
		int     ya, ma, da, yb, mb, db;
		longint na;
		longint off;

		// calendar corners
		add_request(KIND_SHIFT, 1, 1, 1, 0, 0, 0, 0, 1'b0);
		add_request(KIND_SHIFT, 1, 1, 1, -1, 16383, 15, 31, 1'b0);
		add_request(KIND_SHIFT, MAX_YEAR, 12, 31, 1, 0, 0, 0, 1'b0);
		add_request(KIND_SHIFT, MAX_YEAR, 12, 31, 0, 0, 0, 0, 1'b0);
		add_request(KIND_SHIFT, 2000, 2, 28, 1, 0, 0, 0, 1'b0);
		add_request(KIND_SHIFT, 1900, 2, 28, 1, 0, 0, 0, 1'b0);
		add_request(KIND_SHIFT, 2024, 3, 1, -1, 0, 0, 0, 1'b0);
		add_request(KIND_SHIFT, 1999, 12, 31, 1, 0, 0, 0, 1'b0);
		add_request(KIND_SHIFT, 2000, 1, 1, -1, 0, 0, 0, 1'b0);
		add_request(KIND_SHIFT, 5000, 6, 15, OFF_MAX, 0, 0, 0, 1'b0);
		add_request(KIND_SHIFT, 5000, 6, 15, OFF_MIN, 0, 0, 0, 1'b0);
		// malformed dates
		add_request(KIND_SHIFT, 2023, 2, 29, 0, 0, 0, 0, 1'b0);
		add_request(KIND_SHIFT, 2023, 0, 10, 5, 0, 0, 0, 1'b0);
		add_request(KIND_SHIFT, 2023, 13, 10, 5, 0, 0, 0, 1'b0);
		add_request(KIND_SHIFT, 2023, 4, 0, 5, 0, 0, 0, 1'b0);
		add_request(KIND_SHIFT, 2023, 4, 31, 5, 0, 0, 0, 1'b0);
		add_request(KIND_SHIFT, 0, 1, 1, 5, 0, 0, 0, 1'b0);
		add_request(KIND_SHIFT, MAX_YEAR + 1, 1, 1, 0, 0, 0, 0, 1'b0);
		add_request(KIND_SHIFT, 16383, 15, 31, -1, 16383, 15, 31, 1'b0);
		// differences; hold the first until the block has drained
		add_request(KIND_DIFF, 2024, 7, 4, 0, 2024, 7, 4, 1'b1);
		add_request(KIND_DIFF, 1, 1, 1, OFF_MAX, MAX_YEAR, 12, 31, 1'b0);
		add_request(KIND_DIFF, MAX_YEAR, 12, 31, OFF_MIN, 1, 1, 1, 1'b0);
		add_request(KIND_DIFF, 2000, 3, 1, 0, 2000, 2, 28, 1'b0);
		add_request(KIND_DIFF, 2023, 5, 5, 0, 2100, 2, 29, 1'b0);
		add_request(KIND_DIFF, 1600, 2, 30, 0, 1600, 2, 29, 1'b0);

		for (i = 0; i < RANDOM_ITEMS; i++) begin
			kind = 1'($urandom_range(0, 1));
			random_date(ya, ma, da);
			random_date(yb, mb, db);
			if ($urandom_range(0, 9) == 0) begin
				ya = $urandom_range(0, 16383);
				ma = $urandom_range(0, 15);
				da = $urandom_range(0, 31);
			end
			if (kind == KIND_DIFF && $urandom_range(0, 9) == 0) begin
				yb = $urandom_range(0, 16383);
				mb = $urandom_range(0, 15);
				db = $urandom_range(0, 31);
			end
			na = day_index(ya, ma, da);
			case ($urandom_range(0, 5))
				0: off = int'($urandom_range(0, 800)) - 400;
				1: off = int'($urandom_range(0, 80000)) - 40000;
				// land on, or just past, either end of the calendar
				2: off = -na + int'($urandom_range(0, 2)) - 1;
				3: off = year_start(longint'(MAX_YEAR) + 1) - 1 - na + int'($urandom_range(0, 2)) - 1;
				default: off = int'($urandom_range(0, 2097151)) + OFF_MIN;
			endcase
			if (off > OFF_MAX || off < OFF_MIN) begin
				off = int'($urandom_range(0, 2097151)) + OFF_MIN;
			end
			add_request(kind, ya, ma, da, int'(off), yb, mb, db, i % 200 == 100);
		end

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		wait (date_requests.size() == 0 && taken_cnt == sent_cnt
			&& predicted_results.size() == 0);
		repeat (SETTLE_TIME) @(posedge clk);

		$display("Covered %0d items: %0d date shifts and %0d date differences.",
			taken_cnt, shift_cnt, diff_cnt);
		$display("%0d had an invalid date, %0d shifted out of range; %0d results compared.",
			bad_cnt, range_cnt, checked_cnt);
		if (err_cnt == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

FILE: sim.f
+incdir+sv
sv/gda_pkg.sv
sv/gda_ucode_rom.sv
sv/gda_datapath.sv
sv/gregorian_date_arithmetic.sv
test/tb_gregorian_date_arithmetic.sv
